FILE: src/fpfa_pkg.sv
// Package for the fixed partition fit allocator.
// Holds widths, policy and status codes, register indexes, reset capacities
// and the controller-to-datapath command struct. No dependencies.
package fpfa_pkg;

  localparam int NUM_PARTS = 5;
  localparam int PART_W    = 3;
  localparam int SIZE_W    = 8;
  localparam int OWNER_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  // Fit policy codes
  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } fit_policy_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ALLOC    = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_RELEASED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Opcodes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE4  = 3'd5;

  // Capacities after reset
  typedef logic [SIZE_W-1:0] size_arr_t [NUM_PARTS];
  localparam size_arr_t SIZE_RESET = '{8'd8, 8'd4, 8'd2, 8'd1, 8'd1};

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming beat
    logic commit;  // decide, update state, register result
  } dp_cmd_t;

endpackage

FILE: src/fpfa_ctrl.sv
// Controller for the fixed partition fit allocator.
// Two-state sequencer: capture a beat, then evaluate it. Uses fpfa_pkg.
module fpfa_ctrl import fpfa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output dp_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  // Next state: evaluate each accepted beat in S_EVAL, then return to S_IDLE
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EVAL;
      S_EVAL: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt == S_EVAL);
  end

  // Hold state and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy       = busy_r;
  assign cmd.load   = start && !busy_r;
  assign cmd.commit = busy_r;

  a_eval_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r) else $error("evaluate lasted more than one cycle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> busy_r) else $error("accepted beat not evaluated");

  a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r == S_EVAL)) else $error("busy out of step with state");

endmodule

FILE: src/fpfa_dp.sv
// Datapath for the fixed partition fit allocator.
// Config registers, occupancy, owner table, fit search and result register.
// Uses fpfa_pkg; driven by fpfa_ctrl commands.
module fpfa_dp import fpfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd_i,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_opcode,
  input  logic [SIZE_W-1:0]    in_request_size,
  input  logic [OWNER_W-1:0]   in_owner_id,
  input  logic [PART_W-1:0]    in_target_partition,
  output logic                 out_strobe,
  output logic [1:0]           out_status,
  output logic [PART_W-1:0]    out_chosen_partition,
  output logic [OWNER_W-1:0]   out_result_owner
);

  // Configuration
  fit_policy_t           policy_r;
  logic [SIZE_W-1:0]     size_r [NUM_PARTS];
  logic [CFG_IDX_W-1:0]  size_sel;

  // Allocation state
  logic [NUM_PARTS-1:0]  occupied_r, occupied_nxt;
  logic [OWNER_W-1:0]    owner_r [NUM_PARTS];
  logic [PART_W-1:0]     nfs_r, nfs_nxt;

  // Captured beat
  logic                  op_r;
  logic [SIZE_W-1:0]     need_r;
  logic [OWNER_W-1:0]    owner_in_r;
  logic [PART_W-1:0]     target_r;

  // Result register
  logic                  strobe_r;
  status_t               status_r, status_nxt;
  logic [PART_W-1:0]     chosen_r, chosen_nxt;
  logic [OWNER_W-1:0]    res_owner_r, res_owner_nxt;

  // Search
  logic [NUM_PARTS-1:0]  fit_vec;
  logic [SIZE_W-1:0]     left [NUM_PARTS];
  logic                  found;
  logic [PART_W-1:0]     pick;
  logic                  wr_owner;

  assign size_sel = cfg_index - CFG_SIZE0;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIRST;
      for (int i = 0; i < NUM_PARTS; i++) size_r[i] <= SIZE_RESET[i];
    end else if (cfg_we) begin
      if (cfg_index == CFG_POLICY) begin
        policy_r <= fit_policy_t'(cfg_wdata[1:0]);
      end else if (cfg_index >= CFG_SIZE0 && cfg_index <= CFG_SIZE4) begin
        size_r[size_sel] <= cfg_wdata[SIZE_W-1:0];
      end
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r       <= in_opcode;
      need_r     <= in_request_size;
      owner_in_r <= in_owner_id;
      target_r   <= in_target_partition;
    end
  end

  // Per-partition fit and leftover
  always_comb begin
    for (int i = 0; i < NUM_PARTS; i++) begin
      fit_vec[i] = !occupied_r[i] && (need_r <= size_r[i]);
      left[i]    = size_r[i] - need_r;
    end
  end

  // Select a partition under the active policy
  always_comb begin
    logic [SIZE_W-1:0] best_left;
    logic [PART_W-1:0] start_idx;
    logic [PART_W:0]   rot;
    logic [PART_W-1:0] idx;
    found     = 1'b0;
    pick      = '0;
    best_left = '0;
    start_idx = (nfs_r < PART_W'(NUM_PARTS)) ? nfs_r : '0;
    rot       = '0;
    idx       = '0;
    unique case (policy_r)
      POL_FIRST: begin
        for (int i = NUM_PARTS - 1; i >= 0; i--) begin
          if (fit_vec[i]) begin
            found = 1'b1;
            pick  = PART_W'(i);
          end
        end
      end
      POL_BEST, POL_WORST: begin
        for (int i = 0; i < NUM_PARTS; i++) begin
          if (fit_vec[i] && (!found ||
              ((policy_r == POL_BEST) ? (left[i] <= best_left)
                                      : (left[i] >= best_left)))) begin
            found     = 1'b1;
            pick      = PART_W'(i);
            best_left = left[i];
          end
        end
      end
      POL_NEXT: begin
        for (int k = 0; k < NUM_PARTS; k++) begin
          rot = {1'b0, start_idx} + (PART_W+1)'(k);
          if (rot >= (PART_W+1)'(NUM_PARTS)) rot = rot - (PART_W+1)'(NUM_PARTS);
          idx = rot[PART_W-1:0];
          if (!found && fit_vec[idx]) begin
            found = 1'b1;
            pick  = idx;
          end
        end
      end
      default: found = 1'b0;
    endcase
  end

  // Decide the result and next state
  always_comb begin
    occupied_nxt  = occupied_r;
    nfs_nxt       = nfs_r;
    status_nxt    = ST_NOFIT;
    chosen_nxt    = '0;
    res_owner_nxt = '0;
    wr_owner      = 1'b0;
    if (op_r == OP_ALLOC) begin
      if (found) begin
        occupied_nxt[pick] = 1'b1;
        wr_owner           = 1'b1;
        if (policy_r == POL_NEXT) nfs_nxt = pick;
        status_nxt    = ST_ALLOC;
        chosen_nxt    = pick;
        res_owner_nxt = owner_in_r;
      end
    end else if (target_r < PART_W'(NUM_PARTS)) begin
      chosen_nxt = target_r;
      if (occupied_r[target_r]) begin
        occupied_nxt[target_r] = 1'b0;
        status_nxt    = ST_RELEASED;
        res_owner_nxt = owner_r[target_r];
      end else begin
        status_nxt = ST_EMPTY;
      end
    end else begin
      status_nxt = ST_EMPTY;
    end
  end

  // Advance allocation state and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occupied_r <= '0;
      nfs_r      <= '0;
      strobe_r   <= 1'b0;
    end else begin
      strobe_r <= cmd_i.commit;
      if (cmd_i.commit) begin
        occupied_r <= occupied_nxt;
        nfs_r      <= nfs_nxt;
      end
    end
  end

  // Owner table and result payload
  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      if (wr_owner) owner_r[pick] <= owner_in_r;
      status_r    <= status_nxt;
      chosen_r    <= chosen_nxt;
      res_owner_r <= res_owner_nxt;
    end
  end

  assign out_strobe           = strobe_r;
  assign out_status           = status_r;
  assign out_chosen_partition = chosen_r;
  assign out_result_owner     = res_owner_r;

  a_occ_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_i.commit |=> $stable(occupied_r)) else $error("occupancy changed while idle");

  a_strobe_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(cmd_i.commit)) else $error("result beat without evaluate");

  a_grant_is_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && status_r == ST_ALLOC) |-> occupied_r[chosen_r])
    else $error("granted partition not marked occupied");

endmodule

FILE: src/fixed_partition_fit_allocator_unit.sv
// Top level of the fixed partition fit allocator.
// Joins fpfa_ctrl and fpfa_dp; uses fpfa_pkg.
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------------
//  in_      | start, busy      | opcode, request_size, owner_id, target_partition
//  out_     | out_strobe       | status, chosen_partition, result_owner
//  cfg_     | cfg_we           | cfg_index, cfg_wdata
//
// An accepted beat is captured in one cycle and evaluated in the next, so busy
// is high for one cycle and a new beat cannot be taken while busy is high.
// The result strobes in the cycle after evaluation; the receiver cannot stall it.
// Rate is set by the two-state controller ahead of the single fit search unit.
// Reset is synchronous; no clearing pass is needed, the block is ready at once.
module fixed_partition_fit_allocator_unit import fpfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_opcode,
  input  logic [SIZE_W-1:0]    in_request_size,
  input  logic [OWNER_W-1:0]   in_owner_id,
  input  logic [PART_W-1:0]    in_target_partition,
  output logic                 out_strobe,
  output logic [1:0]           out_status,
  output logic [PART_W-1:0]    out_chosen_partition,
  output logic [OWNER_W-1:0]   out_result_owner,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;

  fpfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  fpfa_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_i                (cmd),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_opcode            (in_opcode),
    .in_request_size      (in_request_size),
    .in_owner_id          (in_owner_id),
    .in_target_partition  (in_target_partition),
    .out_strobe           (out_strobe),
    .out_status           (out_status),
    .out_chosen_partition (out_chosen_partition),
    .out_result_owner     (out_result_owner)
  );

endmodule
